// ----- hw/rtl/wcx_pkg.sv -----
// package: field widths, register indexes and reset values for the word tokenizer
`timescale 1ns / 1ps

package wcx_pkg;

  localparam int CHAR_W   = 8;
  localparam int TOTAL_W  = 16;
  localparam int DSET_W   = 64;
  localparam int DCNT_W   = 4;
  localparam int WIDX_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_SET   = 2'd0,
    REG_DELIM_COUNT = 2'd1,
    REG_WORD_INDEX  = 2'd2,
    REG_COUNT_ONLY  = 2'd3
  } cfg_reg_t;

  localparam logic [DSET_W-1:0] DELIM_SET_RST   = 64'h0000_0000_0A0D_0920;
  localparam logic [DCNT_W-1:0] DELIM_COUNT_RST = 4'd4;
  localparam logic [WIDX_W-1:0] WORD_INDEX_RST  = 16'd0;
  localparam logic              COUNT_ONLY_RST  = 1'b1;

endpackage

// ----- hw/rtl/word_count_and_extract.sv -----
// top level: delimiter-set word tokenizer, one byte per transfer
`timescale 1ns / 1ps
// Usage
//   in_*  : one string byte per transfer, in_tdata = char_in, in_tlast marks the
//           final byte of the string.
//   out_* : one result per input byte, out_tdata = {word_total, char_out},
//           out_tuser = in_selected_word, out_tlast = copy of in_tlast.
//   cfg_* : register writes (delimiter set, delimiter count, word index,
//           count-only), taken at any edge with cfg_we high; write only
//           while no byte is in flight.
// Pipeline
//   The input transfer is captured in the input register; the delimiter
//   compare and count update then feed the result register, which drives
//   the result transfer.
//   Throughput is one byte per cycle while out_tready is high; the word count
//   update is a loop through the string state registers.
// Reset
//   rst_n low clears both pipeline valids and the string state and loads
//   the register reset values (space, tab, CR, LF; count-only mode).
// Stall
//   While out_tready is low the result holds and the input register keeps
//   its byte; in_tready drops only when both stages are full.
module word_count_and_extract #(
  parameter int MAX_DELIMS = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wcx_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] char_in
  input  logic                               in_tlast,   // last_in
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wcx_pkg::OUT_DATA_W-1:0]     out_tdata,  // [7:0] char_out, [23:8] word_total
  output logic                               out_tuser,  // [0] in_selected_word
  output logic                               out_tlast,  // last_out
  input  logic                               cfg_we,
  input  logic [wcx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wcx_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import wcx_pkg::*;

  localparam int TW = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [DCNT_W-1:0] MAX_DELIMS_C = DCNT_W'(MAX_DELIMS);

  // configuration registers
  logic [DSET_W-1:0] delim_set_r;
  logic [DCNT_W-1:0] delim_count_r;
  logic [WIDX_W-1:0] word_index_r;
  logic              count_only_r;

  // input stage
  logic              v1_r;
  logic [CHAR_W-1:0] char1_r;
  logic              last1_r;

  // result stage
  logic               v2_r;
  logic [CHAR_W-1:0]  char2_r;
  logic [TOTAL_W-1:0] total2_r;
  logic               sel2_r;
  logic               last2_r;

  // string state
  logic                  prior_delim_r, prior_delim_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  term_r, term_nxt;

  logic                  adv;
  logic                  step;
  logic [DCNT_W-1:0]     n_eff;
  logic                  is_delim;
  logic                  term_now;
  logic [COUNT_BITS-1:0] count_new;
  logic                  prior_new;
  logic                  sel_nxt;
  logic [TW-1:0]         count_ext;
  logic [TOTAL_W-1:0]    total_nxt;

  assign adv       = !v2_r || out_tready;
  assign in_tready = !v1_r || adv;
  assign step      = v1_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_set_r   <= DELIM_SET_RST;
      delim_count_r <= DELIM_COUNT_RST;
      word_index_r  <= WORD_INDEX_RST;
      count_only_r  <= COUNT_ONLY_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELIM_SET:   delim_set_r   <= cfg_wdata[DSET_W-1:0];
        REG_DELIM_COUNT: delim_count_r <= cfg_wdata[DCNT_W-1:0];
        REG_WORD_INDEX:  word_index_r  <= cfg_wdata[WIDX_W-1:0];
        REG_COUNT_ONLY:  count_only_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // delimiter match over the used slots, zero slots ignored
  always_comb begin
    n_eff = (delim_count_r > MAX_DELIMS_C) ? MAX_DELIMS_C : delim_count_r;
    is_delim = 1'b0;
    for (int k = 0; k < MAX_DELIMS; k++) begin
      if ((DCNT_W'(k) < n_eff) && (delim_set_r[8*k +: 8] != '0) &&
          (delim_set_r[8*k +: 8] == char1_r)) begin
        is_delim = 1'b1;
      end
    end
  end

  always_comb begin
    term_now  = term_r || (char1_r == '0);
    count_new = count_r;
    prior_new = prior_delim_r;
    sel_nxt   = 1'b0;
    if (!term_now) begin
      if (!is_delim && prior_delim_r && (count_r < COUNT_MAX)) begin
        count_new = count_r + COUNT_ONE;
      end
      prior_new = is_delim;
      if (!count_only_r && (word_index_r != '0) && !is_delim &&
          (TW'(count_new) == TW'(word_index_r))) begin
        sel_nxt = 1'b1;
      end
    end
    count_ext = TW'(count_new);
    if (count_ext > TW'({TOTAL_W{1'b1}})) begin
      total_nxt = {TOTAL_W{1'b1}};
    end else begin
      total_nxt = count_ext[TOTAL_W-1:0];
    end
    if (last1_r) begin
      prior_delim_nxt = 1'b1;
      count_nxt       = '0;
      term_nxt        = 1'b0;
    end else begin
      prior_delim_nxt = prior_new;
      count_nxt       = count_new;
      term_nxt        = term_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_delim_r <= 1'b1;
      count_r       <= '0;
      term_r        <= 1'b0;
    end else if (step) begin
      prior_delim_r <= prior_delim_nxt;
      count_r       <= count_nxt;
      term_r        <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_tready) begin
        v1_r <= in_tvalid;
      end
      if (adv) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char1_r <= in_tdata[CHAR_W-1:0];
      last1_r <= in_tlast;
    end
    if (step) begin
      char2_r  <= char1_r;
      total2_r <= total_nxt;
      sel2_r   <= sel_nxt;
      last2_r  <= last1_r;
    end
  end

  assign out_tvalid = v2_r;
  assign out_tdata  = {total2_r, char2_r};
  assign out_tuser  = sel2_r;
  assign out_tlast  = last2_r;

endmodule

// ----- dv/tb_top.sv -----
// testbench: word tokenizer checked transfer by transfer against a built-in predictor
`timescale 1ns / 1ps

module tb_top;
  import wcx_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } char_xfer_t;

  typedef struct packed {
    logic [7:0]  chr;
    logic        sel;
    logic [15:0] total;
    logic        last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  word_count_and_extract dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] char_in
    .in_tlast   (in_tlast),    // last_in
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] char_out, [23:8] word_total
    .out_tuser  (out_tuser),   // [0] in_selected_word
    .out_tlast  (out_tlast),   // last_out
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // register shadows
  logic [DSET_W-1:0] delim_set_q = DELIM_SET_RST;
  logic [DCNT_W-1:0] delim_cnt_q = DELIM_COUNT_RST;
  logic [WIDX_W-1:0] word_idx_q = WORD_INDEX_RST;
  logic count_only_q = COUNT_ONLY_RST;

  // string state
  logic prev_delim = 1'b1;
  logic [15:0] word_cnt = '0;
  logic stopped = 1'b0;

  char_xfer_t pending_chars[$];
  token_t expected_tokens[$];
  char_xfer_t cur_char;
  token_t mon_got, mon_want;

  bit idle_on = 1'b1;
  int send_gap = 0;
  int recv_stall = 0;
  int err_cnt = 0;
  int n_bytes = 0;
  int n_strings = 0;
  int n_cfg_writes = 0;
  int n_results = 0;
  int n_selected = 0;
  int max_total = 0;
  int cycle_cnt = 0;

  function automatic logic is_delim(logic [7:0] c);
    int n;
    logic [7:0] d;
    n = (delim_cnt_q > 8) ? 8 : delim_cnt_q;
    for (int k = 0; k < n; k++) begin
      d = delim_set_q[8*k +: 8];
      if (d != 8'h00 && d == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic token_t tokenize_byte(char_xfer_t x);
    token_t r;
    logic d;
    r.chr = x.chr;
    r.sel = 1'b0;
    r.last = x.last;
    if (x.chr == 8'h00) stopped = 1'b1;
    if (!stopped) begin
      d = is_delim(x.chr);
      if (!d && prev_delim && word_cnt != 16'hFFFF) word_cnt = word_cnt + 16'd1;
      prev_delim = d;
      if (!count_only_q && word_idx_q != '0 && !d && word_cnt == word_idx_q) r.sel = 1'b1;
    end
    r.total = word_cnt;
    if (x.last) begin
      prev_delim = 1'b1;
      word_cnt = '0;
      stopped = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_delim();
    logic [7:0] pool[$];
    int n;
    n = (delim_cnt_q > 8) ? 8 : delim_cnt_q;
    for (int k = 0; k < n; k++)
      if (delim_set_q[8*k +: 8] != 8'h00) pool.push_back(delim_set_q[8*k +: 8]);
    if (pool.size() == 0) return $urandom_range(1, 255);
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = $urandom_range(1, 255); while (is_delim(c));
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) expected_tokens.push_back(tokenize_byte(cur_char));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          cur_char = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur_char.chr;
          in_tlast <= cur_char.last;
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        mon_got = '{chr: out_tdata[7:0], sel: out_tuser, total: out_tdata[23:8],
                    last: out_tlast};
        n_results++;
        if (mon_got.sel) n_selected++;
        if (mon_got.total > max_total) max_total = mon_got.total;
        if (expected_tokens.size() == 0) begin
          $error("unexpected transfer: char_out %0h word_total %0d", mon_got.chr,
                 mon_got.total);
          err_cnt++;
        end else begin
          mon_want = expected_tokens.pop_front();
          if (mon_got.chr !== mon_want.chr) begin
            $error("char_out: expected %0h, got %0h", mon_want.chr, mon_got.chr);
            err_cnt++;
          end
          if (mon_got.sel !== mon_want.sel) begin
            $error("in_selected_word: expected %0b, got %0b", mon_want.sel, mon_got.sel);
            err_cnt++;
          end
          if (mon_got.total !== mon_want.total) begin
            $error("word_total: expected %0d, got %0d", mon_want.total, mon_got.total);
            err_cnt++;
          end
          if (mon_got.last !== mon_want.last) begin
            $error("last_out: expected %0b, got %0b", mon_want.last, mon_got.last);
            err_cnt++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             expected_tokens.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_DELIM_SET:   delim_set_q = val;
      REG_DELIM_COUNT: delim_cnt_q = val[DCNT_W-1:0];
      REG_WORD_INDEX:  word_idx_q = val[WIDX_W-1:0];
      REG_COUNT_ONLY:  count_only_q = val[0];
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic push_chars(logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++)
      pending_chars.push_back('{chr: s[i], last: (i == s.size() - 1)});
    n_bytes += s.size();
    n_strings++;
  endtask

  task automatic push_text(string txt);
    logic [7:0] s[$];
    for (int i = 0; i < txt.len(); i++) s.push_back(txt[i]);
    push_chars(s);
  endtask

  task automatic add_random_string();
    logic [7:0] s[$];
    int kind;
    int nw;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 24)) s.push_back($urandom_range(0, 255));
    end else begin
      nw = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) s.push_back(pick_delim());
      for (int w = 0; w < nw; w++) begin
        repeat ($urandom_range(1, 6)) s.push_back(pick_plain());
        repeat ($urandom_range(1, 3)) s.push_back(pick_delim());
      end
      if (s.size() == 0 || $urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 5)) s.push_back(pick_plain());
      // early terminator somewhere in the string
      if (kind < 5) s.insert($urandom_range(0, s.size()), 8'h00);
    end
    push_chars(s);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_tvalid || expected_tokens.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [7:0] tmp[$];
    logic [63:0] dset;
    int goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset register values first
    push_text("hi yo");
    drain();
    write_reg(REG_COUNT_ONLY, 64'd0);
    write_reg(REG_WORD_INDEX, 64'd2);
    push_text("\tab cd\n");
    tmp = {8'hFF, 8'h20, 8'h01, 8'h00, 8'h41};
    push_chars(tmp);
    drain();
    // zero slots inside the delimiter set
    write_reg(REG_DELIM_SET, 64'h2C00_0000_0000_003B);
    write_reg(REG_DELIM_COUNT, 64'd8);
    push_text("a;b,c");
    drain();
    write_reg(REG_DELIM_COUNT, 64'd15);
    push_text("p,");
    drain();
    write_reg(REG_DELIM_COUNT, 64'd0);
    write_reg(REG_WORD_INDEX, 64'd1);
    push_text("a b");
    drain();
    write_reg(REG_WORD_INDEX, 64'd0);
    push_text("a");
    drain();

    // random part, one register setting per phase
    for (int p = 0; p < 8; p++) begin
      dset = {$urandom, $urandom};
      for (int k = 0; k < 8; k++)
        if ($urandom_range(0, 3) == 0) dset[8*k +: 8] = 8'h00;
      if (p == 1) dset = '1;
      if (p == 2) dset = '0;
      write_reg(REG_DELIM_SET, dset);
      case (p)
        2: write_reg(REG_DELIM_COUNT, 64'd8);
        5: write_reg(REG_DELIM_COUNT, 64'd0);
        6: write_reg(REG_DELIM_COUNT, 64'd15);
        7: write_reg(REG_DELIM_COUNT, 64'd9);
        default: write_reg(REG_DELIM_COUNT, 64'($urandom_range(1, 8)));
      endcase
      case (p)
        3: write_reg(REG_WORD_INDEX, 64'd0);
        4: write_reg(REG_WORD_INDEX, 64'hFFFF);
        5: write_reg(REG_WORD_INDEX, 64'($urandom_range(0, 65535)));
        default: write_reg(REG_WORD_INDEX, 64'($urandom_range(1, 6)));
      endcase
      write_reg(REG_COUNT_ONLY, (p == 0 || p == 6) ? 64'd1 : 64'd0);
      idle_on = (p != 2 && p != 5);
      goal = n_bytes + 220;
      while (n_bytes < goal) add_random_string();
      drain();
    end

    repeat (8) @(negedge clk);
    $display("covered %0d bytes in %0d strings over %0d register writes", n_bytes,
             n_strings, n_cfg_writes);
    $display("checked %0d results, %0d flagged as selected, peak word total %0d",
             n_results, n_selected, max_total);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
